### hdl/itfa_pkg.sv
// Shared types and constants for the integer to ASCII field formatter.
`timescale 1ns / 1ps
package itfa_pkg;

  localparam int unsigned ValW = 64;

  // Configuration register indexes.
  localparam logic [6:0] RegRadix     = 7'd0;
  localparam logic [6:0] RegPrecision = 7'd1;
  localparam logic [6:0] RegUnsigned  = 7'd2;
  localparam logic [6:0] RegSignPlus  = 7'd3;
  localparam logic [6:0] RegWidth     = 7'd4;
  localparam logic [6:0] RegMinDigits = 7'd5;

  // Radix codes.
  localparam logic [1:0] RadixBin = 2'd0;
  localparam logic [1:0] RadixOct = 2'd1;
  localparam logic [1:0] RadixDec = 2'd2;
  localparam logic [1:0] RadixHex = 2'd3;

  // Precision codes.
  localparam logic [1:0] Prec64 = 2'd0;
  localparam logic [1:0] Prec32 = 2'd1;
  localparam logic [1:0] Prec16 = 2'd2;
  localparam logic [1:0] Prec8  = 2'd3;

  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChBlank = 8'h20;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [1:0] radix;
    logic [1:0] prec;
    logic       unsgn;
    logic       plus;
    logic [6:0] width;
    logic [6:0] min_digits;
  } cfg_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load;     // capture value, form magnitude and sign
    logic digit;    // extract one digit
    logic emit;     // drive one character
  } cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic mag_zero;
    logic digs_full;
  } sts_t;

  // Map a digit 0..15 to ASCII, hex upper case.
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    digit_char = (d > 4'd9) ? (ChZero + 8'(d) + 8'd7) : (ChZero + 8'(d));
  endfunction

endpackage

### hdl/itfa_ctrl.sv
// Controller state machine: load, digit extraction loop and character emission.
`timescale 1ns / 1ps
module itfa_ctrl import itfa_pkg::*; #(
  parameter int unsigned CntW = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [CntW-1:0] width_i,
  input  sts_t            sts_i,
  output cmd_t            cmd_o,
  output logic [CntW-1:0] pos_o,
  output logic            busy_o
);

  typedef enum logic [1:0] {StIdle, StDigit, StSetup, StEmit} state_e;

  state_e          state_q;
  logic [CntW-1:0] pos_q;

  // One clocked block holds state and the emit position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pos_q   <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            state_q <= StDigit;
          end
        end
        StDigit: begin
          if (sts_i.mag_zero || sts_i.digs_full) begin
            state_q <= StSetup;
          end
        end
        StSetup: begin
          pos_q <= '0;
          if (width_i == '0) begin
            state_q <= StIdle;
          end else begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          pos_q <= pos_q + 1'b1;
          if (pos_q + 1'b1 == width_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Command decode.
  always_comb begin
    cmd_o       = '0;
    cmd_o.load  = (state_q == StIdle) && start_i;
    cmd_o.digit = (state_q == StDigit) && !sts_i.mag_zero && !sts_i.digs_full;
    cmd_o.emit  = (state_q == StEmit);
  end

  assign pos_o  = pos_q;
  assign busy_o = (state_q != StIdle);

endmodule

### hdl/itfa_dpath.sv
// Datapath: magnitude, digit store, field layout and character output.
`timescale 1ns / 1ps
module itfa_dpath import itfa_pkg::*; #(
  parameter int unsigned CntW = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic [ValW-1:0] value_i,
  input  cmd_t            cmd_i,
  input  logic [CntW-1:0] pos_i,
  input  logic [CntW-1:0] width_i,
  output sts_t            sts_o,
  output logic [7:0]      char_out_o,
  output logic            last_o,
  output logic            star_filled_o,
  output logic            strobe_o
);

  // Rounded-up 2^23 / 10; exact for every chunk numerator below 2^22.
  localparam logic [19:0] DivRecip = 20'd838861;

  logic [ValW-1:0]  mag_q, mag_d, mask, topbit, masked;
  logic [63:0][3:0] digs_q;
  logic [6:0]       nd_q;
  logic             neg_q, plus_q;
  logic [7:0]       used, lead;
  logic             stars;
  logic [7:0]       ch;
  logic [7:0]       from_right;
  logic             emit_digit;
  logic [1:0]       ck_q;
  logic [3:0]       rem_q;
  logic [47:0]      quot_hi_q;
  logic [19:0]      div_num, div_rem;
  logic [39:0]      div_prod;
  logic [15:0]      div_quo;
  logic             dig_done;

  // Precision mask.
  always_comb begin
    case (cfg_i.prec)
      Prec32:  mask = 64'h0000_0000_FFFF_FFFF;
      Prec16:  mask = 64'h0000_0000_0000_FFFF;
      Prec8:   mask = 64'h0000_0000_0000_00FF;
      default: mask = '1;
    endcase
    topbit = (mask >> 1) + 64'd1;
    masked = value_i & mask;
  end

  // Divide by ten one 16-bit chunk per cycle, most significant chunk first.
  // The running remainder is prepended to each chunk and the chunk quotient
  // comes from a reciprocal multiply, so a decimal digit takes all four chunks.
  always_comb begin
    div_num  = {rem_q, mag_q[{ck_q, 4'b0000} +: 16]};
    div_prod = 40'(div_num) * 40'(DivRecip);
    div_quo  = div_prod[38:23];
    div_rem  = div_num - 20'(div_quo) * 20'd10;
  end

  // Next magnitude and digit for the selected radix.
  always_comb begin
    mag_d = mag_q;
    case (cfg_i.radix)
      RadixBin: begin
        mag_d = mag_q >> 1;
      end
      RadixOct: begin
        mag_d = mag_q >> 3;
      end
      RadixHex: begin
        mag_d = mag_q >> 4;
      end
      default: begin
        mag_d = {quot_hi_q, div_quo};
      end
    endcase
  end

  logic [3:0] cur_dig;
  always_comb begin
    case (cfg_i.radix)
      RadixBin: cur_dig = {3'b000, mag_q[0]};
      RadixOct: cur_dig = {1'b0, mag_q[2:0]};
      RadixHex: cur_dig = mag_q[3:0];
      default:  cur_dig = div_rem[3:0];
    endcase
  end

  // A digit is complete after one step, or after the last chunk in decimal.
  assign dig_done = cmd_i.digit && ((cfg_i.radix != RadixDec) || (ck_q == 2'd0));

  // Magnitude, sign, digit count and division registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nd_q      <= '0;
      neg_q     <= 1'b0;
      plus_q    <= 1'b0;
      mag_q     <= '0;
      ck_q      <= 2'd3;
      rem_q     <= '0;
      quot_hi_q <= '0;
    end else if (cmd_i.load) begin
      nd_q  <= '0;
      ck_q  <= 2'd3;
      rem_q <= '0;
      if (!cfg_i.unsgn && ((masked & topbit) != '0)) begin
        mag_q  <= (~masked + 64'd1) & mask;
        neg_q  <= 1'b1;
        plus_q <= 1'b0;
      end else begin
        mag_q  <= masked;
        neg_q  <= 1'b0;
        plus_q <= !cfg_i.unsgn && cfg_i.plus &&
                  ((masked != '0) || (cfg_i.min_digits != '0));
      end
    end else if (cmd_i.digit) begin
      if (dig_done) begin
        mag_q <= mag_d;
        nd_q  <= nd_q + 7'd1;
        ck_q  <= 2'd3;
        rem_q <= '0;
      end else begin
        quot_hi_q[{ck_q - 2'd1, 4'b0000} +: 16] <= div_quo;
        rem_q <= div_rem[3:0];
        ck_q  <= ck_q - 2'd1;
      end
    end
  end

  // Digit shift register: the newest digit enters at the bottom, so the most
  // significant digit sits there when emission starts and each emitted digit
  // shifts the next one down.
  always_ff @(posedge clk_i) begin
    if (dig_done) begin
      digs_q <= {digs_q[62:0], cur_dig};
    end else if (cmd_i.emit && emit_digit) begin
      digs_q <= {4'd0, digs_q[63:1]};
    end
  end

  assign sts_o.mag_zero  = (mag_q == '0);
  assign sts_o.digs_full = nd_q[6];

  // Field layout.
  always_comb begin
    used  = (nd_q > cfg_i.min_digits) ? {1'b0, nd_q} : {1'b0, cfg_i.min_digits};
    used  = used + {7'd0, (neg_q | plus_q)};
    stars = used > {1'b0, width_i};
    lead  = {1'b0, width_i} - 8'(pos_i) - 8'd1;
    from_right = lead;
    emit_digit = !stars && (from_right < {1'b0, nd_q});
    if (stars) begin
      ch = ChStar;
    end else if (emit_digit) begin
      ch = digit_char(digs_q[0]);
    end else if (from_right < {1'b0, cfg_i.min_digits}) begin
      ch = ChZero;
    end else if ((neg_q | plus_q) && (from_right == used - 8'd1)) begin
      ch = neg_q ? ChMinus : ChPlus;
    end else begin
      ch = ChBlank;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_o <= 1'b0;
    end else begin
      strobe_o <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      char_out_o    <= ch;
      last_o        <= (8'(pos_i) + 8'd1 == {1'b0, width_i});
      star_filled_o <= stars;
    end
  end

endmodule

### hdl/int_to_formatted_ascii_field.sv
// Top level of the integer to right-justified ASCII field formatter.
// Usage: write configuration through cfg_we_i / cfg_idx_i / cfg_data_i
// while the block is idle. Raise start with value_i while busy is low;
// the word is taken at that edge. The block first extracts digits, one per
// cycle in binary, octal and hex and one per four chunk steps in decimal (up to
// 64 binary, 22 octal, 20 decimal or 16 hex digits; none for a zero value),
// sees the loop end and passes through a setup state, then emits one
// character per cycle on char_out_o with strobe_o high, leftmost first;
// last_o marks the rightmost character and star_filled_o an overflowed field.
// A width of zero gives no characters and a width above MAX_WIDTH is cut
// to MAX_WIDTH.
// Reset loads the register defaults (decimal, 64 bits, signed, width 20,
// one minimum digit) and returns the controller to idle.
// The receiver cannot stall: each character is valid for one cycle only.
`timescale 1ns / 1ps
module int_to_formatted_ascii_field import itfa_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] value_i,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_idx_i,
  input  logic [6:0]  cfg_data_i,
  output logic        strobe_o,
  output logic [7:0]  char_out_o,
  output logic        last_o,
  output logic        star_filled_o
);

  localparam int unsigned CntW = 7;

  cfg_t       cfg_q;
  cmd_t       cmd;
  sts_t       sts;
  logic [6:0] pos, width_sat;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radix      <= RadixDec;
      cfg_q.prec       <= Prec64;
      cfg_q.unsgn      <= 1'b0;
      cfg_q.plus       <= 1'b0;
      cfg_q.width      <= 7'd20;
      cfg_q.min_digits <= 7'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRadix:     cfg_q.radix      <= cfg_data_i[1:0];
        RegPrecision: cfg_q.prec       <= cfg_data_i[1:0];
        RegUnsigned:  cfg_q.unsgn      <= cfg_data_i[0];
        RegSignPlus:  cfg_q.plus       <= cfg_data_i[0];
        RegWidth:     cfg_q.width      <= cfg_data_i;
        RegMinDigits: cfg_q.min_digits <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Field width saturated at the maximum.
  assign width_sat = ({25'd0, cfg_q.width} > MAX_WIDTH) ? 7'(MAX_WIDTH) : cfg_q.width;

  itfa_ctrl #(.CntW(CntW)) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .width_i (width_sat),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .pos_o   (pos),
    .busy_o  (busy)
  );

  itfa_dpath #(.CntW(CntW)) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .pos_i         (pos),
    .width_i       (width_sat),
    .sts_o         (sts),
    .char_out_o    (char_out_o),
    .last_o        (last_o),
    .star_filled_o (star_filled_o),
    .strobe_o      (strobe_o)
  );

  // A character is only emitted while an item is in progress or just ending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(busy)) else $error("character without an item");

  // A new item is never loaded during emission.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !cmd.load) else $error("load during emission");

  // After the last character the next cycle carries no character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_o) |=> !strobe_o) else $error("character after last");

endmodule
